### hw/rtl/two_level_page_table_updater_core_defines.svh
// ----------------------------------------------------------------------------
// Page table updater assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_UPDATER_CORE_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_UPDATER_CORE_DEFINES_SVH

// same-cycle implication
`define PTU_AST_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define PTU_AST_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

### hw/rtl/ptu_pkg.sv
// ----------------------------------------------------------------------------
// ptu_pkg
// Types and constants shared by the page table updater modules.
// ----------------------------------------------------------------------------
package ptu_pkg;

  // request kinds
  localparam logic [2:0] REQ_MAP    = 3'd0;
  localparam logic [2:0] REQ_UNMAP  = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_KERNEL = 3'd3;
  localparam logic [2:0] REQ_TASK   = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_POOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_POOL   = 1'b1;

  localparam logic [31:0] PAGE_MASK    = 32'hFFFF_F000;
  localparam logic [31:0] PAGE_BYTES   = 32'h0000_1000;
  localparam logic [31:0] PDE_FLAGS    = 32'h0000_0007;
  localparam logic [31:0] PRESENT_BIT  = 32'h0000_0001;
  localparam logic [31:0] KERNEL_RESET = 32'h0001_0000;
  localparam logic [31:0] TASK_RESET   = 32'h0002_0000;

  localparam int TABLE_WORDS = 1024;
  localparam int TBL_IDX_W   = 10;
  localparam int PAGE_SHIFT  = 12;
  localparam int DIR_SHIFT   = 22;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 104;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        in_store;  // a lies on a page inside the store
  } alu_rsp_t;

endpackage

### hw/rtl/two_level_page_table_updater_core.sv
// ----------------------------------------------------------------------------
// two_level_page_table_updater_core
// Map/unmap of 4 KiB pages in two-level tables kept in a local word store,
// page present-bit clearing and kernel/task page allocators.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Content
// in_      in   tvalid/tready      request kind (tuser), addresses/flags (tdata)
// out_     out  tvalid/tready      status (tuser), entry/page results (tdata)
// cfg_     in   cfg_we             pool start registers, write only
//
// Map with a present directory entry and unmap: DISP reads the directory
// entry, PDR picks the table (unmap also reads its entry), ENTRY or ERD
// writes the entry and FIN hands the result on. Allocator requests, unknown
// kinds and a bad directory address go from DISP to FIN; a bad table address
// goes from PDR to FIN. Map that builds a new table and page clear also pass
// the one-word-a-cycle present-bit sweep over 1024 entries through the single
// store read port. After reset a clearing pass zeroes the store with in_tready
// low. A stalled result is held; one new request may be in work meanwhile and
// waits at its end for the output register.
// ----------------------------------------------------------------------------
`include "two_level_page_table_updater_core_defines.svh"

module two_level_page_table_updater_core import ptu_pkg::*; #(
  parameter int STORE_PAGES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: virtual_address[31:0], directory_base[63:32],
  //           physical_address[95:64], attributes[107:96], zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type[2:0]
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: entry_address[31:0], entry_value[63:32], table_created[64],
  //            page_taken[96:65], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: status[0]
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [31:0]            cfg_wdata
);

  localparam int PB          = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int AW          = PB + TBL_IDX_W;
  localparam int STORE_WORDS = STORE_PAGES * TABLE_WORDS;
  localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);
  localparam int SW = TBL_IDX_W + 1;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DISP  = 3'd2;
  localparam logic [2:0] ST_PDR   = 3'd3;
  localparam logic [2:0] ST_ERD   = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;
  localparam logic [2:0] ST_ENTRY = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [SW-1:0] sweep_cnt_r;
  logic [AW-1:0] sweep_wa_r;
  logic          rd_pend_r;

  logic [2:0]  req_r;
  logic [31:0] va_r, dbase_r, phys_r;
  logic [11:0] attr_r;
  logic [31:0] kern_r, task_r, table_r;

  logic        res_status_r, res_created_r;
  logic [31:0] res_eaddr_r, res_evalue_r, res_taken_r;

  logic        out_valid_r, out_status_r, out_created_r;
  logic [31:0] out_eaddr_r, out_evalue_r, out_taken_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd, mem_rd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic          need_map;
  logic [31:0]   table_sel;
  logic [AW-1:0] pd_idx, ent_idx, sel_ent_idx, sweep_ra;
  logic [31:0]   map_value;
  logic          out_free;

  ptu_store #(.AW(AW), .DEPTH(STORE_WORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  ptu_alu #(.STORE_PAGES(STORE_PAGES)) u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign need_map    = (req_r == REQ_MAP) && !mem_rd[0];
  assign table_sel   = need_map ? kern_r : (mem_rd & PAGE_MASK);
  assign pd_idx      = {dbase_r[PAGE_SHIFT +: PB], va_r[31:DIR_SHIFT]};
  assign ent_idx     = {table_r[PAGE_SHIFT +: PB], va_r[21:PAGE_SHIFT]};
  assign sel_ent_idx = {table_sel[PAGE_SHIFT +: PB], va_r[21:PAGE_SHIFT]};
  assign sweep_ra    = {table_r[PAGE_SHIFT +: PB], sweep_cnt_r[TBL_IDX_W-1:0]};
  assign map_value   = (phys_r & PAGE_MASK) | PRESENT_BIT | {20'd0, attr_r};
  assign out_free    = !out_valid_r || out_tready;

  // shared unit operand select
  always_comb begin
    alu_req = '0;
    if (st_r == ST_DISP) begin
      case (req_r)
        REQ_KERNEL: alu_req = '{a: kern_r, b: PAGE_BYTES};
        REQ_TASK:   alu_req = '{a: task_r, b: PAGE_BYTES};
        default:    alu_req = '{a: dbase_r, b: 32'd0};
      endcase
    end else if (st_r == ST_PDR) begin
      alu_req = '{a: table_sel, b: PAGE_BYTES};
    end
  end

  // store ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    unique case (st_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
      end
      ST_DISP: begin
        if ((req_r == REQ_MAP || req_r == REQ_UNMAP) && alu_rsp.in_store) begin
          mem_re = 1'b1;
          mem_ra = pd_idx;
        end
      end
      ST_PDR: begin
        if (alu_rsp.in_store) begin
          if (need_map) begin
            mem_we = 1'b1;
            mem_wa = pd_idx;
            mem_wd = kern_r | PDE_FLAGS;
          end else if (req_r == REQ_UNMAP) begin
            mem_re = 1'b1;
            mem_ra = sel_ent_idx;
          end
        end
      end
      ST_ERD: begin
        mem_we = 1'b1;
        mem_wa = ent_idx;
        mem_wd = mem_rd & ~PRESENT_BIT;
      end
      ST_SWEEP: begin
        // read word k while writing back word k-1
        mem_we = rd_pend_r;
        mem_wa = sweep_wa_r;
        mem_wd = mem_rd & ~PRESENT_BIT;
        mem_re = !sweep_cnt_r[SW-1];
        mem_ra = sweep_ra;
      end
      ST_ENTRY: begin
        mem_we = 1'b1;
        mem_wa = ent_idx;
        mem_wd = map_value;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_cnt_r == LAST_WORD) st_nxt = ST_IDLE;
      ST_IDLE: if (in_tvalid) st_nxt = ST_DISP;
      ST_DISP: begin
        case (req_r) inside
          REQ_MAP, REQ_UNMAP: st_nxt = alu_rsp.in_store ? ST_PDR : ST_FIN;
          REQ_CLEAR:          st_nxt = alu_rsp.in_store ? ST_SWEEP : ST_FIN;
          default:            st_nxt = ST_FIN;
        endcase
      end
      ST_PDR: begin
        if (!alu_rsp.in_store)       st_nxt = ST_FIN;
        else if (need_map)           st_nxt = ST_SWEEP;
        else if (req_r == REQ_MAP)   st_nxt = ST_ENTRY;
        else                         st_nxt = ST_ERD;
      end
      ST_ERD:   st_nxt = ST_FIN;
      ST_SWEEP: begin
        if (sweep_cnt_r[SW-1]) st_nxt = (req_r == REQ_MAP) ? ST_ENTRY : ST_FIN;
      end
      ST_ENTRY: st_nxt = ST_FIN;
      ST_FIN:   if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_cnt_r   <= '0;
      sweep_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      kern_r      <= KERNEL_RESET;
      task_r      <= TASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rd_pend_r <= (st_r == ST_SWEEP) && !sweep_cnt_r[SW-1];

      if (st_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end

      if (st_r == ST_SWEEP) begin
        if (!sweep_cnt_r[SW-1]) sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end else begin
        sweep_cnt_r <= '0;
      end

      if (st_r == ST_DISP && req_r == REQ_KERNEL) kern_r <= alu_rsp.sum;
      if (st_r == ST_DISP && req_r == REQ_TASK)   task_r <= alu_rsp.sum;
      if (st_r == ST_PDR && alu_rsp.in_store && need_map) kern_r <= alu_rsp.sum;

      // writing a pool start reloads its allocator
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_KERNEL_POOL: kern_r <= cfg_wdata & PAGE_MASK;
          CFG_TASK_POOL:   task_r <= cfg_wdata & PAGE_MASK;
          default: begin
          end
        endcase
      end

      if (st_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and per-request result registers
  always_ff @(posedge clk) begin
    sweep_wa_r <= sweep_ra;

    if (st_r == ST_IDLE && in_tvalid) begin
      req_r         <= in_tuser;
      va_r          <= in_tdata[31:0];
      dbase_r       <= in_tdata[63:32] & PAGE_MASK;
      phys_r        <= in_tdata[95:64];
      attr_r        <= in_tdata[107:96];
      res_status_r  <= 1'b0;
      res_created_r <= 1'b0;
      res_eaddr_r   <= '0;
      res_evalue_r  <= '0;
      res_taken_r   <= '0;
    end

    unique case (st_r)
      ST_DISP: begin
        case (req_r) inside
          REQ_MAP, REQ_UNMAP, REQ_CLEAR: begin
            res_status_r <= !alu_rsp.in_store;
            table_r      <= dbase_r;
          end
          REQ_KERNEL: res_taken_r <= kern_r;
          REQ_TASK:   res_taken_r <= task_r;
          default: begin
          end
        endcase
      end
      ST_PDR: begin
        res_status_r <= !alu_rsp.in_store;
        table_r      <= table_sel;
        if (alu_rsp.in_store && need_map) begin
          res_created_r <= 1'b1;
          res_taken_r   <= table_sel;
        end
      end
      ST_ERD: begin
        res_eaddr_r  <= {table_r[31:PAGE_SHIFT], va_r[21:PAGE_SHIFT], 2'b00};
        res_evalue_r <= mem_rd & ~PRESENT_BIT;
      end
      ST_ENTRY: begin
        res_eaddr_r  <= {table_r[31:PAGE_SHIFT], va_r[21:PAGE_SHIFT], 2'b00};
        res_evalue_r <= map_value;
      end
      default: begin
      end
    endcase

    if (st_r == ST_FIN && out_free) begin
      out_status_r  <= res_status_r;
      out_eaddr_r   <= res_eaddr_r;
      out_evalue_r  <= res_evalue_r;
      out_created_r <= res_created_r;
      out_taken_r   <= res_taken_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_taken_r, out_created_r, out_evalue_r, out_eaddr_r};

  `PTU_AST_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `PTU_AST_IMP(a_no_rw_clash, mem_we && mem_re, mem_wa != mem_ra, "store read meets write")
  `PTU_AST_IMP(a_sweep_bound, st_r == ST_SWEEP && sweep_cnt_r[SW-1],
               sweep_cnt_r[TBL_IDX_W-1:0] == '0, "sweep overran the table")
  `PTU_AST_IMP(a_created_ok, out_tvalid && out_tdata[64], !out_tuser,
               "new table reported with error status")

endmodule

### hw/rtl/ptu_store.sv
// ----------------------------------------------------------------------------
// ptu_store
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptu_store #(
  parameter int AW    = 16,
  parameter int DEPTH = 65536
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem_r [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ptu_alu.sv
// ----------------------------------------------------------------------------
// ptu_alu
// Shared adder and store range compare used by the DISP and PDR sequencer steps.
// ----------------------------------------------------------------------------
module ptu_alu import ptu_pkg::*; #(
  parameter int STORE_PAGES = 64
) (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  always_comb begin
    rsp.sum      = req.a + req.b;
    // aligned word accesses: in store iff the page number is below the page count
    rsp.in_store = ({12'd0, req.a[31:PAGE_SHIFT]} < 32'(STORE_PAGES));
  end

endmodule

### tb/ptu_checker.sv
// ----------------------------------------------------------------------------
// ptu_checker
// Watches the request, result and register ports of the page table updater.
// It keeps its own word store and page allocators, works out each request's
// result when the request is taken, and compares results in arrival order.
// ----------------------------------------------------------------------------
module ptu_checker import ptu_pkg::*; #(
  parameter int STORE_PAGES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // in_tdata: virtual_address[31:0], directory_base[63:32],
  //           physical_address[95:64], attributes[107:96], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type[2:0]
  input  logic [2:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: entry_address[31:0], entry_value[63:32], table_created[64],
  //            page_taken[96:65], zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: status[0]
  input  logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [31:0]            cfg_wdata,
  output int                     fail_count,
  output int                     results_due
);
  localparam int          STORE_WORDS = STORE_PAGES * TABLE_WORDS;
  localparam logic [32:0] STORE_BYTES = 33'(STORE_PAGES) << PAGE_SHIFT;

  typedef struct packed {
    logic        status;
    logic [31:0] entry_addr;
    logic [31:0] entry_val;
    logic        created;
    logic [31:0] page;
  } update_t;

  logic [31:0] words [STORE_WORDS];
  logic [31:0] kernel_next;
  logic [31:0] user_next;
  update_t     update_q[$];

  function automatic logic fits(input logic [31:0] addr);
    return ({1'b0, addr} + 33'd3) < STORE_BYTES;
  endfunction

  function automatic int word_of(input logic [31:0] addr);
    return int'((addr >> 2) % STORE_WORDS);
  endfunction

  function automatic void clear_present(input logic [31:0] page);
    int w;
    for (int i = 0; i < TABLE_WORDS; i++) begin
      w = word_of(page + 32'(i * 4));
      words[w] = words[w] & ~PRESENT_BIT;
    end
  endfunction

  // Applies one request to the shadow tables and returns what the block
  // should report for it.
  function automatic update_t predict_update(input logic [2:0] kind,
                                             input logic [31:0] va,
                                             input logic [31:0] dir_raw,
                                             input logic [31:0] pa,
                                             input logic [11:0] attr);
    update_t     r;
    logic [31:0] dir_page;
    logic [31:0] pde_addr;
    logic [31:0] tbl_off;
    logic [31:0] tbl;
    logic [31:0] pte_addr;
    logic        fresh;
    r        = '0;
    dir_page = dir_raw & PAGE_MASK;
    pde_addr = dir_page + {20'd0, va[31:22], 2'b00};
    tbl_off  = {20'd0, va[21:12], 2'b00};
    case (kind)
      REQ_MAP: begin
        if (!fits(pde_addr)) begin
          r.status = 1'b1;
        end else begin
          fresh = !words[word_of(pde_addr)][0];
          tbl   = fresh ? kernel_next : (words[word_of(pde_addr)] & PAGE_MASK);
          if (!fits(tbl + tbl_off) || (fresh && !fits(tbl + PAGE_BYTES - 32'd4))) begin
            r.status = 1'b1;
          end else begin
            if (fresh) begin
              kernel_next = kernel_next + PAGE_BYTES;
              // directory entry goes in before the sweep, which may hit it
              words[word_of(pde_addr)] = tbl | PDE_FLAGS;
              clear_present(tbl);
              r.created = 1'b1;
              r.page    = tbl;
            end
            r.entry_addr = tbl + tbl_off;
            r.entry_val  = (pa & PAGE_MASK) | PRESENT_BIT | {20'd0, attr};
            words[word_of(r.entry_addr)] = r.entry_val;
          end
        end
      end
      REQ_UNMAP: begin
        if (!fits(pde_addr)) begin
          r.status = 1'b1;
        end else begin
          // no present check on the directory entry
          pte_addr = (words[word_of(pde_addr)] & PAGE_MASK) + tbl_off;
          if (!fits(pte_addr)) begin
            r.status = 1'b1;
          end else begin
            r.entry_val  = words[word_of(pte_addr)] & ~PRESENT_BIT;
            r.entry_addr = pte_addr;
            words[word_of(pte_addr)] = r.entry_val;
          end
        end
      end
      REQ_CLEAR: begin
        if (!fits(dir_page + PAGE_BYTES - 32'd4) || !fits(dir_page)) r.status = 1'b1;
        else clear_present(dir_page);
      end
      REQ_KERNEL: begin
        r.page      = kernel_next;
        kernel_next = kernel_next + PAGE_BYTES;
      end
      REQ_TASK: begin
        r.page    = user_next;
        user_next = user_next + PAGE_BYTES;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    update_t want;
    update_t got;
    if (!rst_n) begin
      for (int i = 0; i < STORE_WORDS; i++) words[i] = '0;
      kernel_next = KERNEL_RESET;
      user_next   = TASK_RESET;
      update_q.delete();
      fail_count  = 0;
      results_due = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_KERNEL_POOL) kernel_next = cfg_wdata & PAGE_MASK;
        else if (cfg_addr == CFG_TASK_POOL) user_next = cfg_wdata & PAGE_MASK;
      end
      if (in_tvalid && in_tready)
        update_q.push_back(predict_update(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                          in_tdata[95:64], in_tdata[107:96]));
      if (out_tvalid && out_tready) begin
        got.status     = out_tuser;
        got.entry_addr = out_tdata[31:0];
        got.entry_val  = out_tdata[63:32];
        got.created    = out_tdata[64];
        got.page       = out_tdata[96:65];
        if (update_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result transaction with no request outstanding: status=%0d %h",
                     $time, out_tuser, out_tdata);
        end else begin
          want = update_q.pop_front();
          if (got.status !== want.status || got.entry_addr !== want.entry_addr ||
              got.entry_val !== want.entry_val || got.created !== want.created ||
              got.page !== want.page) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch exp: status=%0d addr=%h value=%h created=%0d page=%h",
                       $time, want.status, want.entry_addr, want.entry_val, want.created,
                       want.page);
              $display("[%0t]          got: status=%0d addr=%h value=%h created=%0d page=%h",
                       $time, got.status, got.entry_addr, got.entry_val, got.created,
                       got.page);
            end
          end
        end
      end
      results_due = update_q.size();
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives map, unmap, page clear, allocator and unknown-kind requests into the page table
// updater under several pool settings and idle/stall mixes; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import ptu_pkg::*;

  localparam int STORE_PAGES     = 64;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 160;
  // covers the post-reset store clear several times over
  localparam int QUIET_LIMIT     = 300000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [2:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [31:0]            cfg_wdata;

  int          fail_count;
  int          results_due;
  logic        in_fire;
  int          quiet_cycles;
  int          send_idle_pct;
  int          stall_pct;
  logic [31:0] mapped_va[$];
  logic [31:0] mapped_dir[$];
  logic [31:0] dir_pages[2];
  logic [9:0]  dir_slots[4];

  two_level_page_table_updater_core #(.STORE_PAGES(STORE_PAGES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  ptu_checker #(.STORE_PAGES(STORE_PAGES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .results_due(results_due)
  );

  always #5 clk = ~clk;

  always @(negedge clk) out_tready <= rst_n && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** two_level_page_table_updater_core: FAILED **");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction,
  // with in_tvalid still high.
  task automatic send_req(input logic [2:0] kind, input logic [31:0] va,
                          input logic [31:0] dir, input logic [31:0] pa,
                          input logic [11:0] attr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, attr, pa, dir, va};
    do @(negedge clk); while (in_fire !== 1'b1);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  task automatic set_pools(input logic [31:0] kern_pool, input logic [31:0] user_pool);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_KERNEL_POOL;
    cfg_wdata <= kern_pool;
    @(negedge clk);
    cfg_addr  <= CFG_TASK_POOL;
    cfg_wdata <= user_pool;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int          pick;
    int          k;
    logic [31:0] va;
    logic [31:0] dir;
    logic [31:0] kern_pool;
    logic [31:0] user_pool;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, pools at their reset values
    send_req(REQ_KERNEL, 32'h0, 32'h0, 32'h0, 12'h0);
    send_req(REQ_TASK, '1, '1, '1, 12'hFFF);
    // absent directory entry: new table from the kernel pool
    send_req(REQ_MAP, 32'h0040_3ABC, 32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF);
    send_req(REQ_MAP, 32'h007F_F000, 32'h0, 32'h0, 12'h0);
    // that table used as a directory: present entry points outside the store
    send_req(REQ_MAP, 32'h00C0_0000, 32'h0001_1000, 32'h1234_5678, 12'h800);
    send_req(REQ_UNMAP, 32'h00C0_0000, 32'h0001_1000, 32'h0, 12'h0);
    send_req(REQ_UNMAP, 32'h0040_3000, 32'h0, 32'h0, 12'h0);
    // unmap through a directory entry that is not present
    send_req(REQ_UNMAP, 32'h0080_5000, 32'h0, '1, 12'hFFF);
    send_req(REQ_MAP, 32'hFFC0_0000, 32'hFFFF_F000, 32'h0000_1000, 12'h001);
    send_req(REQ_MAP, 32'hFFFF_FFFF, 32'h0003_F000, 32'hABCD_E000, 12'h555);
    send_req(REQ_MAP, 32'h0, 32'h0004_0000, 32'h0, 12'h0);
    send_req(REQ_CLEAR, 32'h0, 32'h0003_F000, 32'h0, 12'h0);
    send_req(REQ_CLEAR, 32'h0, 32'h0004_0000, 32'h0, 12'h0);
    send_req(REQ_CLEAR, '1, 32'hFFFF_FFFF, '1, 12'hFFF);
    // directory entry lost its present bit in the clear above
    send_req(REQ_MAP, 32'hFFC0_1000, 32'h0003_F000, 32'h5555_5000, 12'hAAA);
    send_req(3'd5, '1, '1, '1, 12'hFFF);
    send_req(3'd6, 32'h0, 32'h0, 32'h0, 12'h0);
    send_req(3'd7, 32'h0040_3000, 32'h0, 32'h0, 12'h0);
    send_req(REQ_KERNEL, '1, '1, '1, 12'hFFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      case (ph)
        1: kern_pool = 32'hFFFF_FFFF;
        3: kern_pool = 32'h0;
        6: kern_pool = 32'h0003_F000;
        default: kern_pool = (32'($urandom_range(60, 8)) << 12) | 32'($urandom_range(4095));
      endcase
      case (ph)
        2: user_pool = 32'h0;
        5: user_pool = 32'hFFFF_FFFF;
        default: user_pool = $urandom;
      endcase
      set_pools(kern_pool, user_pool);
      foreach (dir_pages[i]) dir_pages[i] = 32'($urandom_range(STORE_PAGES - 1)) << 12;
      foreach (dir_slots[i]) dir_slots[i] = 10'($urandom_range(1023));
      mapped_va.delete();
      mapped_dir.delete();

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        va   = {dir_slots[$urandom_range(3)], 10'($urandom_range(1023)), 12'($urandom)};
        dir  = dir_pages[$urandom_range(1)] | 32'($urandom_range(4095));
        if (pick < 35) begin
          send_req(REQ_MAP, va, dir, $urandom, 12'($urandom));
          mapped_va.push_back(va);
          mapped_dir.push_back(dir);
          if (mapped_va.size() > 32) begin
            void'(mapped_va.pop_front());
            void'(mapped_dir.pop_front());
          end
        end else if (pick < 55) begin
          if (mapped_va.size() > 0 && $urandom_range(9) < 7) begin
            k   = $urandom_range(mapped_va.size() - 1);
            va  = mapped_va[k];
            dir = mapped_dir[k];
          end
          send_req(REQ_UNMAP, va, dir, $urandom, 12'($urandom));
        end else if (pick < 62) begin
          // mostly pages inside the store
          if ($urandom_range(4) != 0)
            dir = (32'($urandom_range(STORE_PAGES - 1)) << 12) | 32'($urandom_range(4095));
          else
            dir = $urandom;
          send_req(REQ_CLEAR, $urandom, dir, $urandom, 12'($urandom));
        end else if (pick < 70) begin
          send_req(REQ_KERNEL, $urandom, $urandom, $urandom, 12'($urandom));
        end else if (pick < 76) begin
          send_req(REQ_TASK, $urandom, $urandom, $urandom, 12'($urandom));
        end else begin
          send_req(3'($urandom_range(7)), $urandom, $urandom, $urandom, 12'($urandom));
        end
        if ($urandom_range(63) == 0) drain_results();
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("** two_level_page_table_updater_core: PASSED **");
    else
      $display("** two_level_page_table_updater_core: FAILED **");
    $finish;
  end

endmodule
